@@ sv/cflm_pkg.sv @@
`timescale 1ns / 1ps

package cflm_pkg;

	// Longest literal that can still match
	localparam int unsigned MAX_LEN = 1023;
	localparam int unsigned CNT_W   = $clog2(MAX_LEN + 1);
	localparam int unsigned LEN_W   = 10;

	localparam logic [7:0] CASE_MASK = 8'hdf;
	localparam logic [7:0] CH_E      = 8'h45;
	localparam logic [7:0] CH_F      = 8'h46;
	localparam logic [7:0] CH_POINT  = 8'h2e;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef struct packed {
		logic [7:0] ch;
		logic       start_req;
		logic       final_char;
	} char_item_t;

	typedef struct packed {
		logic             matched;
		logic [LEN_W-1:0] length;
	} res_item_t;

endpackage

@@ sv/c_float_literal_matcher.sv @@
`timescale 1ns / 1ps

// Channel  | handshake                 | payload
// ---------+---------------------------+------------------------------------------
// char     | char_valid / char_stall   | char_item: ch, start_req, final_char
// res      | res_valid / res_stall     | res_item: matched, length
//
// One character per cycle while char_stall is low: a character is registered in
// the input stage, then the scan state and the result register update from it.
// Reset clears the input-stage valid flag, the scan state and the result valid flag.
// char_stall rises only when a character that decides an attempt waits behind
// a stalled result; characters that decide nothing keep flowing meanwhile.
module c_float_literal_matcher (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      char_valid,
	output logic                      char_stall,
	input  cflm_pkg::char_item_t      char_item,
	output logic                      res_valid,
	input  logic                      res_stall,
	output cflm_pkg::res_item_t       res_item
);

	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_MANT      = 3'd1;
	localparam logic [2:0] PH_FRAC      = 3'd2;
	localparam logic [2:0] PH_EXP_START = 3'd3;
	localparam logic [2:0] PH_EXP_SIGN  = 3'd4;
	localparam logic [2:0] PH_EXP_DIG   = 3'd5;

	localparam logic [cflm_pkg::CNT_W-1:0] CNT_MAX = cflm_pkg::CNT_W'(cflm_pkg::MAX_LEN);

	logic                       valid_s1;
	cflm_pkg::char_item_t       item_s1;
	logic [2:0]                 phase_q;
	logic [cflm_pkg::CNT_W-1:0] count_q;
	logic                       saw_digit_q;
	logic                       res_valid_q;
	cflm_pkg::res_item_t        res_q;

	logic                       advance;
	logic                       has_res;
	logic                       res_ok;
	logic [cflm_pkg::CNT_W-1:0] res_len;
	logic [2:0]                 phase_d;
	logic [cflm_pkg::CNT_W-1:0] count_d;
	logic                       saw_digit_d;

	always_comb begin
		logic [2:0]                 ph;
		logic [cflm_pkg::CNT_W-1:0] cnt;
		logic [cflm_pkg::CNT_W-1:0] cnt_inc;
		logic                       sd;
		logic                       can_take;
		logic                       is_digit;
		logic [7:0]                 up;
		logic                       dig_path;
		ph       = item_s1.start_req ? PH_MANT : phase_q;
		cnt      = item_s1.start_req ? '0 : count_q;
		sd       = item_s1.start_req ? 1'b0 : saw_digit_q;
		cnt_inc  = cnt + cflm_pkg::CNT_W'(1);
		can_take = cnt < CNT_MAX;
		is_digit = item_s1.ch inside {[cflm_pkg::CH_ZERO:cflm_pkg::CH_NINE]};
		up       = item_s1.ch & cflm_pkg::CASE_MASK;
		dig_path = 1'b0;

		has_res     = 1'b0;
		res_ok      = 1'b0;
		res_len     = '0;
		phase_d     = ph;
		count_d     = cnt;
		saw_digit_d = sd;

		case (ph)
			PH_MANT: begin
				if (is_digit) begin
					if (can_take) begin
						count_d     = cnt_inc;
						saw_digit_d = 1'b1;
					end else begin
						has_res = 1'b1;
					end
				end else if (item_s1.ch == cflm_pkg::CH_POINT) begin
					if (can_take) begin
						count_d = cnt_inc;
						phase_d = PH_FRAC;
					end else begin
						has_res = 1'b1;
					end
				end else if (sd && up == cflm_pkg::CH_E) begin
					if (can_take) begin
						count_d = cnt_inc;
						phase_d = PH_EXP_START;
					end else begin
						has_res = 1'b1;
					end
				end else if (sd && up == cflm_pkg::CH_F) begin
					// integer run closed by the suffix
					has_res = 1'b1;
					res_ok  = can_take;
					res_len = can_take ? cnt_inc : '0;
				end else begin
					has_res = 1'b1;
				end
			end
			PH_FRAC: begin
				if (is_digit) begin
					if (can_take) begin
						count_d     = cnt_inc;
						saw_digit_d = 1'b1;
					end else begin
						has_res = 1'b1;
					end
				end else if (!sd) begin
					has_res = 1'b1;
				end else if (up == cflm_pkg::CH_E) begin
					if (can_take) begin
						count_d = cnt_inc;
						phase_d = PH_EXP_START;
					end else begin
						has_res = 1'b1;
					end
				end else if (up == cflm_pkg::CH_F) begin
					has_res = 1'b1;
					res_ok  = can_take;
					res_len = can_take ? cnt_inc : '0;
				end else begin
					has_res = 1'b1;
					res_ok  = 1'b1;
					res_len = cnt;
				end
			end
			PH_EXP_START: begin
				if (item_s1.ch == cflm_pkg::CH_PLUS || item_s1.ch == cflm_pkg::CH_MINUS) begin
					if (can_take) begin
						count_d = cnt_inc;
						phase_d = PH_EXP_SIGN;
					end else begin
						has_res = 1'b1;
					end
				end else begin
					dig_path = 1'b1;
				end
			end
			PH_EXP_SIGN: begin
				dig_path = 1'b1;
			end
			PH_EXP_DIG: begin
				if (is_digit) begin
					if (can_take) begin
						count_d = cnt_inc;
					end else begin
						has_res = 1'b1;
					end
				end else if (up == cflm_pkg::CH_F) begin
					has_res = 1'b1;
					res_ok  = can_take;
					res_len = can_take ? cnt_inc : '0;
				end else begin
					has_res = 1'b1;
					res_ok  = 1'b1;
					res_len = cnt;
				end
			end
			default: begin
			end
		endcase

		// first exponent digit, after the E or after its sign
		if (dig_path) begin
			if (is_digit && can_take) begin
				count_d = cnt_inc;
				phase_d = PH_EXP_DIG;
			end else begin
				has_res = 1'b1;
			end
		end

		// text ends here: decide on what has been consumed
		if (!has_res && item_s1.final_char && phase_d != PH_IDLE) begin
			has_res = 1'b1;
			case (phase_d)
				PH_FRAC: begin
					res_ok  = saw_digit_d;
					res_len = saw_digit_d ? count_d : '0;
				end
				PH_EXP_DIG: begin
					res_ok  = 1'b1;
					res_len = count_d;
				end
				default: begin
					res_ok  = 1'b0;
					res_len = '0;
				end
			endcase
		end

		if (has_res) begin
			phase_d = PH_IDLE;
		end
	end

	// hold the stage only when its result cannot enter the result register
	assign advance    = valid_s1 && (!has_res || !res_valid_q || !res_stall);
	assign char_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			item_s1 <= char_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			count_q     <= '0;
			saw_digit_q <= 1'b0;
		end else if (advance) begin
			phase_q     <= phase_d;
			count_q     <= count_d;
			saw_digit_q <= saw_digit_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && has_res) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			res_q.matched <= res_ok;
			res_q.length  <= cflm_pkg::LEN_W'(res_len);
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	a_nomatch_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_item.matched |-> res_item.length == '0)
		else $error("no-match transaction carries a nonzero length");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("consumed count beyond the length limit");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> valid_s1 && res_valid_q && res_stall && has_res)
		else $error("input stalled without a blocked result");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		advance && has_res |=> phase_q == PH_IDLE)
		else $error("scan state not idle after a decided attempt");

endmodule
